FILE: src/sorted_key_table_macros.svh
// Assertion helpers used by the sorted key table RTL.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/skt_pkg.sv
package skt_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_LOOKUP = 3'd1,
        FN_REMOVE = 3'd2,
        FN_FIRST  = 3'd3,
        FN_NEXT   = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_UPD  = 2'b10
    } t_state;

    // Strobes broadcast to every cell of the row.
    typedef struct packed {
        logic cmp;  // compare the incoming key and hold the result
        logic ins;  // insert the held word, shifting upwards
        logic rem;  // remove the first match, shifting downwards
    } t_cell_ctl;

endpackage

FILE: src/skt_cell.sv
module skt_cell
    import skt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic signed [KEY_W-1:0] i_cmp_key,
    input  logic signed [KEY_W-1:0] i_new_key,
    input  logic        [PAY_W-1:0] i_new_payload,
    input  logic signed [KEY_W-1:0] i_left_key,
    input  logic        [PAY_W-1:0] i_left_payload,
    input  logic                    i_left_occ,
    input  logic                    i_left_less,
    input  logic signed [KEY_W-1:0] i_right_key,
    input  logic        [PAY_W-1:0] i_right_payload,
    input  logic                    i_right_occ,
    output logic signed [KEY_W-1:0] o_key,
    output logic        [PAY_W-1:0] o_payload,
    output logic                    o_occ,
    output logic                    o_less,
    output logic                    o_match
);

    logic signed [KEY_W-1:0] r_key, n_key;
    logic        [PAY_W-1:0] r_payload, n_payload;
    logic                    r_occ, n_occ;
    logic                    r_less, n_less;
    logic                    r_eq, n_eq;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        n_occ     = r_occ;
        n_less    = r_less;
        n_eq      = r_eq;
        if (i_ctl.cmp) begin
            n_less = r_occ && (r_key < i_cmp_key);
            n_eq   = r_occ && (r_key == i_cmp_key);
        end
        // Cells below the insertion or removal point keep their word.
        if (i_ctl.ins && !r_less) begin
            n_occ = r_occ | i_left_occ;
            if (i_left_less) begin
                n_key     = i_new_key;
                n_payload = i_new_payload;
            end else begin
                n_key     = i_left_key;
                n_payload = i_left_payload;
            end
        end
        if (i_ctl.rem && !r_less) begin
            n_occ     = i_right_occ;
            n_key     = i_right_key;
            n_payload = i_right_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        if (!i_rst_n) begin
            r_occ  <= 1'b0;
            r_less <= 1'b0;
            r_eq   <= 1'b0;
        end else begin
            r_occ  <= n_occ;
            r_less <= n_less;
            r_eq   <= n_eq;
        end
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_occ     = r_occ;
    assign o_less    = r_less;
    // The first equal key sits just above the last smaller one.
    assign o_match   = r_eq && i_left_less;

endmodule

FILE: src/sorted_key_table.sv
// Sorted key table built as a row of compare-and-shift cells.
// The command word is registered along with the compare result, the row shifts in the update
// state and the result word is registered as it leaves; a new command word is taken only once
// the row is idle again, and a stalled result holds the update state.
// Reset (synchronous, active low) empties the row, clears the count, invalidates the
// traversal cursor and drops any pending result; stored keys need no clearing.
`include "sorted_key_table_macros.svh"

module sorted_key_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0]              i_func,
    input  logic signed [KEY_W-1:0] i_item_key,
    input  logic        [PAY_W-1:0] i_item_payload,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [1:0]              o_status,
    output logic signed [KEY_W-1:0] o_result_key,
    output logic        [PAY_W-1:0] o_result_payload
);

    // Counts and the cursor must be able to hold CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    t_state                  r_state, n_state;
    t_func                   r_func;
    logic signed [KEY_W-1:0] r_key;
    logic        [PAY_W-1:0] r_payload;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_cur_pos, n_cur_pos;
    logic                    r_cur_valid, n_cur_valid;
    logic                    r_out_valid, n_out_valid;
    t_status                 r_status, n_status;
    logic signed [KEY_W-1:0] r_rkey, n_rkey;
    logic        [PAY_W-1:0] r_rpay, n_rpay;

    // Words and flags presented by the cells.
    logic signed [KEY_W-1:0] w_key     [CAPACITY];
    logic        [PAY_W-1:0] w_payload [CAPACITY];
    logic [CAPACITY-1:0]     w_occ;
    logic [CAPACITY-1:0]     w_occ_inc;
    logic [CAPACITY-1:0]     w_less;
    logic [CAPACITY-1:0]     w_match;
    logic [CAPACITY-1:0]     w_rd_sel;

    t_cell_ctl               w_ctl;
    logic                    w_accept;
    logic                    w_commit;
    logic                    w_found;
    logic                    w_full;
    logic [CW-1:0]           w_next_pos;
    logic [CW-1:0]           w_rd_idx;
    logic signed [KEY_W-1:0] w_rd_key;
    logic        [PAY_W-1:0] w_rd_pay;

    // A command word is taken only when the row is idle and reset is released; a
    // result still waiting downstream does not block it, since the output register
    // keeps the two sides apart.
    assign o_stall  = !i_rst_n || (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    // The update cycle completes once the output register can take the result.
    assign w_commit = (r_state == S_UPD) && (!r_out_valid || !i_stall);

    assign w_found    = |w_match;
    assign w_full     = (r_count == CW'(CAPACITY));
    assign w_next_pos = (r_cur_pos < r_count) ? r_cur_pos + CW'(1) : r_cur_pos;
    assign w_rd_idx   = (r_func == FN_FIRST) ? '0 : w_next_pos;

    // Every cell compares the incoming key in the cycle the word is taken,
    // so the update cycle only has to shift.
    always_comb begin
        w_ctl.cmp = w_accept;
        w_ctl.ins = w_commit && (r_func == FN_INSERT) && !w_full;
        w_ctl.rem = w_commit && (r_func == FN_REMOVE) && w_found;
    end

    // The row: cell 0 sees a smaller, occupied neighbour on its left so that
    // it takes the new word when every stored key is at least as large; the
    // last cell pulls in an empty word from its right on removal.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KEY_W-1:0] w_lkey, w_rkey;
        logic        [PAY_W-1:0] w_lpay, w_rpay;
        logic                    w_locc, w_lless, w_rocc;

        if (g == 0) begin : g_left_edge
            assign w_lkey  = r_key;
            assign w_lpay  = r_payload;
            assign w_locc  = 1'b1;
            assign w_lless = 1'b1;
        end else begin : g_left
            assign w_lkey  = w_key[g-1];
            assign w_lpay  = w_payload[g-1];
            assign w_locc  = w_occ[g-1];
            assign w_lless = w_less[g-1];
        end

        if (g == CAPACITY - 1) begin : g_right_edge
            assign w_rkey = w_key[g];
            assign w_rpay = w_payload[g];
            assign w_rocc = 1'b0;
        end else begin : g_right
            assign w_rkey = w_key[g+1];
            assign w_rpay = w_payload[g+1];
            assign w_rocc = w_occ[g+1];
        end

        skt_cell u_cell (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctl           (w_ctl),
            .i_cmp_key       (i_item_key),
            .i_new_key       (r_key),
            .i_new_payload   (r_payload),
            .i_left_key      (w_lkey),
            .i_left_payload  (w_lpay),
            .i_left_occ      (w_locc),
            .i_left_less     (w_lless),
            .i_right_key     (w_rkey),
            .i_right_payload (w_rpay),
            .i_right_occ     (w_rocc),
            .o_key           (w_key[g]),
            .o_payload       (w_payload[g]),
            .o_occ           (w_occ[g]),
            .o_less          (w_less[g]),
            .o_match         (w_match[g])
        );

        // A removal reads the matching cell; a traversal reads the cell the
        // cursor points at. At most one cell is selected either way.
        assign w_rd_sel[g] = (r_func == FN_REMOVE) ? w_match[g]
                                                   : (w_rd_idx == CW'(g));
    end

    always_comb begin
        w_rd_key = '0;
        w_rd_pay = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_rd_sel[i]) begin
                w_rd_key = w_rd_key | w_key[i];
                w_rd_pay = w_rd_pay | w_payload[i];
            end
        end
    end

    // Result and bookkeeping for the command held in the update cycle.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_cur_pos   = r_cur_pos;
        n_cur_valid = r_cur_valid;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_rkey      = r_rkey;
        n_rpay      = r_rpay;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (w_commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = ST_NONE;
                    n_rkey      = '0;
                    n_rpay      = '0;
                    unique case (r_func)
                        FN_INSERT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status    = ST_OK;
                                n_count     = r_count + CW'(1);
                                n_cur_valid = 1'b0;
                            end
                        end
                        FN_LOOKUP: begin
                            if (w_found) begin
                                n_status = ST_OK;
                            end
                        end
                        FN_REMOVE: begin
                            if (w_found) begin
                                n_status    = ST_OK;
                                n_rkey      = w_rd_key;
                                n_rpay      = w_rd_pay;
                                n_count     = r_count - CW'(1);
                                n_cur_valid = 1'b0;
                            end
                        end
                        FN_FIRST: begin
                            n_cur_pos   = '0;
                            n_cur_valid = 1'b1;
                            if (r_count != '0) begin
                                n_status = ST_OK;
                                n_rkey   = w_rd_key;
                                n_rpay   = w_rd_pay;
                            end
                        end
                        FN_NEXT: begin
                            // Past the end the cursor stops at the count.
                            if (r_cur_valid) begin
                                n_cur_pos = w_next_pos;
                                if (w_next_pos < r_count) begin
                                    n_status = ST_OK;
                                    n_rkey   = w_rd_key;
                                    n_rpay   = w_rd_pay;
                                end
                            end
                        end
                        default: begin
                            n_status = ST_NONE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func    <= t_func'(i_func);
            r_key     <= i_item_key;
            r_payload <= i_item_payload;
        end
        r_status <= n_status;
        r_rkey   <= n_rkey;
        r_rpay   <= n_rpay;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cur_pos   <= '0;
            r_cur_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_cur_pos   <= n_cur_pos;
            r_cur_valid <= n_cur_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_result_key     = r_rkey;
    assign o_result_payload = r_rpay;

    // Occupied cells always form an unbroken run from cell 0.
    assign w_occ_inc = w_occ + CAPACITY'(1);

    `SKT_ASSERT_SAME(a_count_matches_row, 1'b1, $countones(w_occ) == int'(r_count),
        "occupied cells disagree with the entry count")
    `SKT_ASSERT_SAME(a_row_is_prefix, 1'b1, (w_occ & w_occ_inc) == '0,
        "occupied cells do not form a run from cell 0")
    `SKT_ASSERT_SAME(a_single_match, r_state == S_UPD, $onehot0(w_match),
        "more than one cell claims the first match")
    `SKT_ASSERT_SAME(a_cursor_in_range, r_cur_valid, r_cur_pos <= r_count,
        "traversal cursor lies beyond the stored entries")
    `SKT_ASSERT_NEXT(a_accept_to_update, w_accept, r_state == S_UPD,
        "an accepted word did not move the row to its update cycle")

endmodule

FILE: test/sorted_key_table_tb.sv
module sorted_key_table_tb
    import skt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The table is built at its usual depth so that the full condition is reached often.
    localparam int TABLE_DEPTH = 16;
    localparam int RANDOM_WORDS = 1500;

    // Function codes that the block does not define. They must still produce a reply,
    // reporting that nothing was found, and leave the table alone.
    localparam logic [2:0] FN_SPARE_A = 3'd5;
    localparam logic [2:0] FN_SPARE_B = 3'd6;
    localparam logic [2:0] FN_SPARE_C = 3'd7;

    localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]         status;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } t_reply;

    // Mirror of the table contents and the traversal cursor, together with the queue
    // of replies that the block still owes. Each accepted command word is applied to
    // the mirror at once; replies come back in order, so the oldest one is compared.
    class sorted_table_checker;
        logic signed [31:0] slot_key[TABLE_DEPTH];
        logic [31:0]        slot_payload[TABLE_DEPTH];
        int                 fill = 0;
        int                 cursor = 0;
        bit                 cursor_ok = 0;
        t_reply             awaited_replies[$];
        int                 mismatches = 0;
        int                 replies_checked = 0;
        int                 func_seen[8];
        int                 full_refusals = 0;
        int                 entries_returned = 0;
        int                 peak_fill = 0;

        function int entries();
            return fill;
        endfunction

        function logic signed [31:0] key_at(int idx);
            return slot_key[idx];
        endfunction

        function int leftover();
            return awaited_replies.size();
        endfunction

        function void note_command(logic [2:0] func, logic signed [31:0] key,
                                   logic [31:0] payload);
            t_reply r;
            int     pos;
            r.status = ST_NONE;
            r.key = '0;
            r.payload = '0;
            func_seen[func]++;
            // Lower bound: first slot whose key is not below the incoming key.
            pos = 0;
            while (pos < fill && slot_key[pos] < key) pos++;
            case (func)
                FN_INSERT: begin
                    if (fill >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                        full_refusals++;
                    end else begin
                        // Equal keys already present end up behind the new one.
                        for (int i = fill; i > pos; i--) begin
                            slot_key[i] = slot_key[i-1];
                            slot_payload[i] = slot_payload[i-1];
                        end
                        slot_key[pos] = key;
                        slot_payload[pos] = payload;
                        fill++;
                        cursor_ok = 0;
                        r.status = ST_OK;
                        if (fill > peak_fill) peak_fill = fill;
                    end
                end
                FN_LOOKUP: begin
                    if (pos < fill && slot_key[pos] == key) r.status = ST_OK;
                end
                FN_REMOVE: begin
                    if (pos < fill && slot_key[pos] == key) begin
                        r.key = slot_key[pos];
                        r.payload = slot_payload[pos];
                        for (int i = pos; i + 1 < fill; i++) begin
                            slot_key[i] = slot_key[i+1];
                            slot_payload[i] = slot_payload[i+1];
                        end
                        fill--;
                        cursor_ok = 0;
                        r.status = ST_OK;
                    end
                end
                FN_FIRST: begin
                    // The cursor becomes valid even on an empty table, standing at the end.
                    cursor = 0;
                    cursor_ok = 1;
                    if (fill > 0) begin
                        r.key = slot_key[0];
                        r.payload = slot_payload[0];
                        r.status = ST_OK;
                    end
                end
                FN_NEXT: begin
                    if (cursor_ok) begin
                        if (cursor < fill) cursor++;
                        if (cursor < fill) begin
                            r.key = slot_key[cursor];
                            r.payload = slot_payload[cursor];
                            r.status = ST_OK;
                        end
                    end
                end
                default: ;
            endcase
            if (r.status == ST_OK && (func == FN_REMOVE || func == FN_FIRST ||
                                      func == FN_NEXT))
                entries_returned++;
            awaited_replies.push_back(r);
        endfunction

        function void check_reply(logic [1:0] status, logic signed [31:0] key,
                                  logic [31:0] payload);
            t_reply want;
            replies_checked++;
            if (awaited_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected reply word: status %0d key %0d payload %h",
                             status, key, payload);
                return;
            end
            want = awaited_replies.pop_front();
            if (status !== want.status || key !== want.key || payload !== want.payload) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("Reply %0d differs: expected status %0d key %0d payload %h, ",
                           replies_checked, want.status, want.key, want.payload);
                    $display("got status %0d key %0d payload %h", status, key, payload);
                end
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [2:0]         i_func = FN_INSERT;
    logic signed [31:0] i_item_key = '0;
    logic [31:0]        i_item_payload = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [1:0]         o_status;
    logic signed [31:0] o_result_key;
    logic [31:0]        o_result_payload;

    sorted_table_checker table_check = new();

    // Number of further words the sender offers back to back before it pauses.
    int burst_left = 0;

    sorted_key_table #(
        .CAPACITY(TABLE_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_item_key       (i_item_key),
        .i_item_payload   (i_item_payload),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_result_key     (o_result_key),
        .o_result_payload (o_result_payload)
    );

    always #5 i_clk = ~i_clk;

    // Offers one command word and holds it steady until the block takes it. Signals are
    // read straight after the edge, so they show the values that the edge itself saw.
    // Once the word is taken the sender either goes straight on with the next one or
    // drops valid for a random gap and then starts a fresh burst.
    task automatic offer_word(logic [2:0] func, logic signed [31:0] key,
                              logic [31:0] payload);
        i_valid <= 1'b1;
        i_func <= func;
        i_item_key <= key;
        i_item_payload <= payload;
        do @(posedge i_clk); while (o_stall);
        table_check.note_command(func, key, payload);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Receiving side. Every taken reply word is checked against the oldest expectation.
    // The stall pattern runs in modes, each chosen at random: no stall at all, light,
    // heavy, or toggling every cycle. Twice during the run the receiver holds off for
    // a long stretch so that the block fills up and has to stall the sender.
    initial begin
        int hold_left;
        int holds_done;
        int mode;
        int mode_left;
        hold_left = 0;
        holds_done = 0;
        mode = 0;
        mode_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall)
                table_check.check_reply(o_status, o_result_key, o_result_payload);
            if (hold_left == 0 && holds_done < 2 &&
                table_check.replies_checked >= 400 + holds_done * 600) begin
                hold_left = 300;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= !i_stall;
                endcase
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int                 phase;
        int                 phase_left;
        int                 sent;
        int                 waited;
        int                 pick;
        logic [2:0]         func;
        logic signed [31:0] key;
        logic [31:0]        payload;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: empty-table corner cases first, then the extreme keys,
        // equal keys, traversal with a miss in the middle, and the cursor being
        // invalidated by an insert.
        offer_word(FN_NEXT, 32'sd0, 32'h0);                 // cursor not yet valid
        offer_word(FN_FIRST, 32'sd0, 32'h0);                // empty: cursor at the end
        offer_word(FN_NEXT, 32'sd0, 32'h0);                 // already past the end
        offer_word(FN_LOOKUP, 32'sd0, 32'h0);
        offer_word(FN_REMOVE, 32'sd0, 32'h0);
        offer_word(FN_INSERT, KEY_MAX, 32'hFFFF_FFFF);
        offer_word(FN_INSERT, KEY_MIN, 32'h0000_0000);
        offer_word(FN_INSERT, 32'sd0, 32'hA5A5_0001);
        offer_word(FN_INSERT, 32'sd0, 32'h5A5A_0002);       // lands ahead of the older zero
        offer_word(FN_INSERT, -32'sd1, 32'h0000_0003);
        offer_word(FN_LOOKUP, 32'sd0, 32'h0);
        offer_word(FN_LOOKUP, 32'sd1, 32'h0);
        offer_word(FN_FIRST, 32'sd0, 32'h0);
        offer_word(FN_NEXT, 32'sd0, 32'h0);
        offer_word(FN_REMOVE, 32'sd7, 32'h0);               // miss keeps the cursor
        offer_word(FN_NEXT, 32'sd0, 32'h0);
        offer_word(FN_INSERT, 32'sd1, 32'h1234_5678);       // invalidates the cursor
        offer_word(FN_NEXT, 32'sd0, 32'h0);
        offer_word(FN_REMOVE, 32'sd0, 32'h0);
        offer_word(FN_REMOVE, KEY_MAX, 32'h0);
        offer_word(FN_SPARE_A, $urandom, $urandom);
        offer_word(FN_SPARE_B, $urandom, $urandom);
        offer_word(FN_SPARE_C, $urandom, $urandom);
        offer_word(FN_FIRST, 32'sd0, 32'h0);

        // Random part, in phases: filling (reaches the full table), draining (empties
        // it), walking (a traverse-first followed by a run of traverse-next that goes
        // past the end), and a mix of all defined codes with the occasional spare code.
        // Keys come mostly from a narrow band or from the table itself, so that
        // lookups and removes hit and equal keys pile up.
        sent = 0;
        phase = 0;
        phase_left = 0;
        while (sent < RANDOM_WORDS) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 3);
                phase_left = $urandom_range(20, 60);
                func = FN_FIRST;
            end
            pick = $urandom_range(0, 99);
            case (phase)
                0: func = (pick < 75) ? FN_INSERT : (pick < 85) ? FN_LOOKUP :
                          (pick < 92) ? FN_FIRST : FN_NEXT;
                1: func = (pick < 75) ? FN_REMOVE : (pick < 90) ? FN_LOOKUP :
                          (pick < 95) ? FN_INSERT : FN_NEXT;
                2: begin
                    if (func != FN_FIRST || phase_left < 20)
                        func = (pick < 85) ? FN_NEXT : (pick < 90) ? FN_FIRST :
                               (pick < 95) ? FN_REMOVE : FN_INSERT;
                end
                default: func = (pick < 4) ? 3'($urandom_range(5, 7)) :
                                3'($urandom_range(0, 4));
            endcase
            phase_left--;

            pick = $urandom_range(0, 9);
            if (pick < 3 && table_check.entries() > 0)
                key = table_check.key_at($urandom_range(0, table_check.entries() - 1));
            else if (pick < 6)
                key = 32'($urandom_range(0, 16)) - 32'd8;
            else if (pick == 6)
                case ($urandom_range(0, 3))
                    0: key = KEY_MIN;
                    1: key = KEY_MAX;
                    2: key = KEY_MIN + 32'sd1;
                    default: key = KEY_MAX - 32'sd1;
                endcase
            else
                key = $urandom;

            case ($urandom_range(0, 9))
                0: payload = '0;
                1: payload = '1;
                default: payload = $urandom;
            endcase

            offer_word(func, key, payload);
            sent++;
        end
        i_valid <= 1'b0;

        // Drain: wait for every owed reply, with a bound, then keep the clock running so
        // that any stray reply word still shows.
        waited = 0;
        while (table_check.leftover() > 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);

        $write("Covered %0d commands: %0d insert, %0d lookup, %0d remove, ",
               24 + sent, table_check.func_seen[FN_INSERT],
               table_check.func_seen[FN_LOOKUP], table_check.func_seen[FN_REMOVE]);
        $write("%0d first, %0d next, %0d spare; ",
               table_check.func_seen[FN_FIRST], table_check.func_seen[FN_NEXT],
               table_check.func_seen[FN_SPARE_A] + table_check.func_seen[FN_SPARE_B] +
               table_check.func_seen[FN_SPARE_C]);
        $display("%0d replies checked.", table_check.replies_checked);
        $write("Peak fill %0d of %0d, %0d inserts refused as full, %0d entries returned; ",
               table_check.peak_fill, TABLE_DEPTH, table_check.full_refusals,
               table_check.entries_returned);
        $display("%0d mismatches, %0d replies missing.",
                 table_check.mismatches, table_check.leftover());
        if (table_check.mismatches == 0 && table_check.leftover() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
